FILE: hdl/gtc_pkg.sv
// Shared constants, types and the control bundle of the transitive closure core.
package gtc_pkg;

    localparam int NODES  = 16;
    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic [NODES-1:0]  row_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [APB_AW-1:0] apb_addr_t;
    typedef logic [APB_DW-1:0] apb_data_t;

    // Register index of node_count, taken from paddr[2].
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam cnt_t NODES_CNT = cnt_t'(NODES);

    // Command bundle broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;
        logic pass;
        logic shift;
        logic add_en;
        idx_t add_src;
        idx_t add_dst;
        idx_t pivot_k;
        row_t keep;
    } cell_ctl_t;

endpackage

FILE: hdl/graph_transitive_closure_core.sv
// Top level of the transitive closure core: register port, sequencer and row cells.
//
// Edge beats (mode 0) are taken one per cycle while the core is idle and set one
// bit of the adjacency row held in the cell of the source vertex; edges with an
// endpoint at or beyond node_count are dropped. Below, n is node_count clamped to
// at most NODES. A closure beat (mode 1) loads every cell with its adjacency row,
// masked to the first n vertices, plus its own vertex bit in the accepting cycle,
// then runs n Warshall passes, one per cycle, with the pivot row broadcast to all
// cells. The rows then leave one per cycle while m_ready is high, through cell 0
// as the chain shifts toward it, and input is held off until the last row beat
// is taken. With node_count 0 a closure beat produces no rows and the core stays
// idle.
module graph_transitive_closure_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  gtc_pkg::apb_addr_t paddr,
    input  gtc_pkg::apb_data_t pwdata,
    output gtc_pkg::apb_data_t prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  gtc_pkg::idx_t      s_edge_from,
    input  gtc_pkg::idx_t      s_edge_to,
    output logic               m_valid,
    input  logic               m_ready,
    output gtc_pkg::idx_t      m_row_index,
    output gtc_pkg::row_t      m_reach_mask,
    output logic               m_last_row
);
    import gtc_pkg::*;

    cnt_t      node_count_reg;
    cell_ctl_t ctl;
    row_t      reach_rows [NODES];
    row_t      next_rows  [NODES];
    row_t      pivot_row;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_NODE_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODES_CNT;
        end else if (cfg_write) begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NODE_COUNT) ? apb_data_t'(node_count_reg) : '0;

    gtc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .node_count  (node_count_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_edge_from (s_edge_from),
        .s_edge_to   (s_edge_to),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_last_row  (m_last_row),
        .ctl         (ctl)
    );

    assign pivot_row = reach_rows[ctl.pivot_k];

    for (genvar i = 0; i < NODES; i++) begin : g_cell
        if (i == NODES - 1) begin : g_tail
            assign next_rows[i] = '0;
        end else begin : g_link
            assign next_rows[i] = reach_rows[i+1];
        end

        gtc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (idx_t'(i)),
            .ctl       (ctl),
            .pivot_row (pivot_row),
            .next_row  (next_rows[i]),
            .reach_row (reach_rows[i])
        );
    end

    assign m_reach_mask = reach_rows[0];

    // Input and output are never open at the same time.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output open together");

    // Every emitted row reaches its own vertex.
    a_self: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_reach_mask[m_row_index])
        else $error("closure row misses its own vertex");

    // After the last row beat the core takes input again.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_row) |=> s_ready)
        else $error("core not idle after last row");

    // An edge beat never produces a row.
    a_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_mode) |=> !m_valid)
        else $error("edge beat produced a row");

endmodule

FILE: hdl/gtc_cell.sv
// One row cell: holds an adjacency row and a closure row of the graph.
module gtc_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  gtc_pkg::idx_t     cell_idx,
    input  gtc_pkg::cell_ctl_t ctl,
    input  gtc_pkg::row_t     pivot_row,
    input  gtc_pkg::row_t     next_row,
    output gtc_pkg::row_t     reach_row
);
    import gtc_pkg::*;

    row_t edge_row_reg, edge_row_next;
    row_t reach_row_reg, reach_row_next;
    row_t self_bit;

    always_comb begin
        self_bit = '0;
        self_bit[cell_idx] = 1'b1;
    end

    always_comb begin
        edge_row_next = edge_row_reg;
        if (ctl.add_en && ctl.add_src == cell_idx) begin
            edge_row_next[ctl.add_dst] = 1'b1;
        end
    end

    // During a pass, a row that already reaches the pivot merges in its reach set.
    always_comb begin
        reach_row_next = reach_row_reg;
        if (ctl.load) begin
            reach_row_next = (edge_row_reg & ctl.keep) | self_bit;
        end else if (ctl.pass) begin
            if (reach_row_reg[ctl.pivot_k]) begin
                reach_row_next = reach_row_reg | pivot_row;
            end
        end else if (ctl.shift) begin
            reach_row_next = next_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_row_reg <= '0;
        end else begin
            edge_row_reg <= edge_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        reach_row_reg <= reach_row_next;
    end

    assign reach_row = reach_row_reg;

endmodule

FILE: hdl/gtc_ctrl.sv
// Sequencer: edge loading, closure passes and row output of the closure core.
module gtc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  gtc_pkg::cnt_t      node_count,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  gtc_pkg::idx_t      s_edge_from,
    input  gtc_pkg::idx_t      s_edge_to,
    output logic               m_valid,
    input  logic               m_ready,
    output gtc_pkg::idx_t      m_row_index,
    output logic               m_last_row,
    output gtc_pkg::cell_ctl_t ctl
);
    import gtc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PASS = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    idx_t cnt_reg, cnt_next;
    cnt_t n_eff;
    idx_t last_idx;
    logic cnt_last;
    logic s_beat;
    row_t keep;

    assign n_eff    = (node_count > NODES_CNT) ? NODES_CNT : node_count;
    assign last_idx = idx_t'(n_eff - cnt_t'(1));
    assign cnt_last = (cnt_reg == last_idx);

    always_comb begin
        for (int j = 0; j < NODES; j++) begin
            keep[j] = (cnt_t'(j) < n_eff);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_beat  = s_valid && s_ready;
    assign m_valid = (state_reg == ST_EMIT);
    assign m_row_index = cnt_reg;
    assign m_last_row  = cnt_last;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_beat && s_mode && n_eff != '0) begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS: begin
                if (cnt_last) begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + idx_t'(1);
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (cnt_last) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + idx_t'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb begin
        ctl.load    = s_beat && s_mode;
        ctl.pass    = (state_reg == ST_PASS);
        ctl.shift   = (state_reg == ST_EMIT) && m_ready;
        ctl.add_en  = s_beat && !s_mode && (cnt_t'(s_edge_from) < n_eff)
                      && (cnt_t'(s_edge_to) < n_eff);
        ctl.add_src = s_edge_from;
        ctl.add_dst = s_edge_to;
        ctl.pivot_k = cnt_reg;
        ctl.keep    = keep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: tb/graph_transitive_closure_core_test.sv
// Self-checking testbench of the transitive closure core, with a closure scoreboard class.
module graph_transitive_closure_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gtc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * NODES + 8;
    localparam apb_addr_t NODE_COUNT_ADDR = apb_addr_t'({REG_NODE_COUNT, 2'b00});

    typedef struct packed {
        idx_t row;
        row_t mask;
        logic last;
    } reach_row_t;

    class closure_scoreboard;
        row_t       edge_rows[NODES];
        logic [4:0] node_count;
        reach_row_t pending_rows[$];
        int         errors;
        int         edges_taken;
        int         closures_run;
        int         rows_checked;

        function new();
            foreach (edge_rows[i]) edge_rows[i] = '0;
            node_count   = 5'd16;
            errors       = 0;
            edges_taken  = 0;
            closures_run = 0;
            rows_checked = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        function int active_count();
            int n;
            n = node_count;
            if (n > NODES) n = NODES;
            if (n > 16) n = 16;
            return n;
        endfunction

        // Edge beats update the adjacency rows; a closure beat queues the rows it must emit.
        function void note_beat(logic mode, idx_t from, idx_t to);
            int         n;
            row_t       keep;
            row_t       reach[NODES];
            reach_row_t entry;
            n = active_count();
            if (!mode) begin
                edges_taken++;
                if (int'(from) < n && int'(to) < n) edge_rows[from][to] = 1'b1;
                return;
            end
            closures_run++;
            keep = '0;
            for (int j = 0; j < n; j++) keep[j] = 1'b1;
            for (int i = 0; i < n; i++) begin
                reach[i]    = edge_rows[i] & keep;
                reach[i][i] = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                for (int i = 0; i < n; i++) begin
                    if (reach[i][k]) reach[i] = reach[i] | reach[k];
                end
            end
            for (int i = 0; i < n; i++) begin
                entry.row    = idx_t'(i);
                entry.mask   = reach[i];
                entry.last   = (i == n - 1);
                pending_rows = {pending_rows, entry};
            end
        endfunction

        task check_row(idx_t row, row_t mask, logic last);
            reach_row_t want;
            if (pending_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected row beat: row %0d mask %h last %b",
                                          row, mask, last));
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (row !== want.row)
                report_mismatch($sformatf("row_index %0d, expected %0d", row, want.row));
            if (mask !== want.mask)
                report_mismatch($sformatf("row %0d reach_mask %h, expected %h",
                                          want.row, mask, want.mask));
            if (last !== want.last)
                report_mismatch($sformatf("row %0d last_row %b, expected %b",
                                          want.row, last, want.last));
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      psel;
    logic      penable;
    logic      pwrite;
    apb_addr_t paddr;
    apb_data_t pwdata;
    apb_data_t prdata;
    logic      pready;
    logic      s_valid;
    logic      s_ready;
    logic      s_mode;
    idx_t      s_edge_from;
    idx_t      s_edge_to;
    logic      m_valid;
    logic      m_ready;
    idx_t      m_row_index;
    row_t      m_reach_mask;
    logic      m_last_row;

    closure_scoreboard sb = new();
    int cycles = 0;
    int burst_left;
    bit gaps_on;

    graph_transitive_closure_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_edge_from  (s_edge_from),
        .s_edge_to    (s_edge_to),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_reach_mask (m_reach_mask),
        .m_last_row   (m_last_row)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("graph_transitive_closure_core verification failed");
            $finish;
        end
    end

    // Row beats are checked at the rising edge; the stall pattern alternates between
    // calm stretches and stretches with random stalls.
    initial begin
        int stall_left;
        int style_left;
        bit stalls_on;
        stall_left = 0;
        style_left = 0;
        stalls_on  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_row(m_row_index, m_reach_mask, m_last_row);
            @(negedge aclk);
            if (style_left == 0) begin
                stalls_on  = ~stalls_on;
                style_left = $urandom_range(40, 300);
            end else begin
                style_left--;
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                m_ready    = 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task send_beat(logic mode, idx_t from, idx_t to);
        int gap;
        @(negedge aclk);
        s_valid     = 1'b1;
        s_mode      = mode;
        s_edge_from = from;
        s_edge_to   = to;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(mode, from, to);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Waits until every expected row has left and the core has had time to go idle.
    task settle;
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes node_count and reads it back.
    task set_node_count(apb_data_t data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = NODE_COUNT_ADDR;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.node_count = data[4:0];
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== apb_data_t'(sb.node_count))
            sb.report_mismatch($sformatf("node_count reads %h, expected %h",
                                         prdata, sb.node_count));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Mostly edges among the active vertices, biased forward so that chains form,
    // with some arbitrary endpoints and a closure now and then; the phase ends in one.
    task run_phase(int beats, int closure_pct);
        int   n;
        int   pick;
        logic mode;
        idx_t from;
        idx_t to;
        idx_t swap;
        n = sb.active_count();
        for (int b = 0; b < beats; b++) begin
            pick = $urandom_range(0, 99);
            from = idx_t'($urandom);
            to   = idx_t'($urandom);
            mode = 1'b0;
            if (b == beats - 1 || pick < closure_pct) begin
                mode = 1'b1;
            end else if (pick < 85 && n > 0) begin
                from = idx_t'($urandom_range(0, n - 1));
                to   = idx_t'($urandom_range(0, n - 1));
                if (pick < 60 && from > to) begin
                    swap = from;
                    from = to;
                    to   = swap;
                end
            end
            send_beat(mode, from, to);
        end
    endtask

    initial begin
        int counts[8];
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_mode      = 1'b0;
        s_edge_from = '0;
        s_edge_to   = '0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: empty graph, corner vertices, self loop, duplicate edges.
        set_node_count(32'd16);
        send_beat(1'b1, 4'd0, 4'd0);
        send_beat(1'b0, 4'd0, 4'd15);
        send_beat(1'b0, 4'd15, 4'd0);
        send_beat(1'b0, 4'd5, 4'd5);
        send_beat(1'b0, 4'd3, 4'd4);
        send_beat(1'b0, 4'd4, 4'd3);
        send_beat(1'b0, 4'd3, 4'd4);
        send_beat(1'b0, 4'd1, 4'd2);
        send_beat(1'b0, 4'd2, 4'd3);
        send_beat(1'b0, 4'd14, 4'd15);
        send_beat(1'b1, 4'd15, 4'd15);
        settle();
        // Count 4: stored edges at vertex 4 and above drop out; new ones there are ignored.
        set_node_count(32'hFFFF_FFE4);
        send_beat(1'b0, 4'd3, 4'd15);
        send_beat(1'b0, 4'd15, 4'd1);
        send_beat(1'b0, 4'd1, 4'd0);
        send_beat(1'b1, 4'd7, 4'd9);
        settle();
        set_node_count(32'd0);
        send_beat(1'b0, 4'd0, 4'd0);
        send_beat(1'b1, 4'd0, 4'd0);
        settle();
        // A count above the vertex limit behaves as the full 16.
        set_node_count(32'd31);
        send_beat(1'b1, 4'd10, 4'd5);
        settle();
        set_node_count(32'd1);
        send_beat(1'b0, 4'd0, 4'd0);
        send_beat(1'b1, 4'd0, 4'd0);
        settle();

        counts = '{3, 7, $urandom_range(1, 16), 0, 12, $urandom_range(17, 31),
                   $urandom_range(1, 16), 16};
        foreach (counts[p]) begin
            set_node_count(apb_data_t'({$urandom, 5'b0}) | apb_data_t'(counts[p]));
            gaps_on = ($urandom_range(0, 3) != 0);
            run_phase(32, 10);
            settle();
        end

        if (sb.pending_rows.size() != 0)
            sb.report_mismatch($sformatf("%0d row beats never arrived", sb.pending_rows.size()));
        $display("Run: %0d edge beats and %0d closure beats sent, %0d row beats compared,",
                 sb.edges_taken, sb.closures_run, sb.rows_checked);
        $display("     with node counts from zero through the clamp above 16.");
        if (sb.errors == 0) begin
            $display("graph_transitive_closure_core verification clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("graph_transitive_closure_core verification failed");
        end
        $finish;
    end

endmodule
